[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the timer slot table.
// Expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AR(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_AR(name, clk, rstn, prop)
`define ASSERT_NR(name, clk, prop)
`endif
`endif

[rtl/ptst_pkg.sv]
// Package for the periodic timer slot table: sizes, codes, slot types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptst_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic RES_REPLY = 1'b0;
  localparam logic RES_FIRE  = 1'b1;

  localparam logic UOP_SET  = 1'b0;
  localparam logic UOP_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] cb;
    logic [31:0] cnt;
    logic [31:0] rld;
  } entry_t;

  typedef struct packed {
    logic   hit;   // set: slot qualifies
    logic   fire;  // tick: slot due
    logic   wr;    // write nxt back
    entry_t nxt;
  } unit_res_t;

  // slot index reduced to the 3-bit result field
  function automatic logic [2:0] slot3(input logic [IDX_W-1:0] i);
    logic [IDX_W+2:0] w;
    w = (IDX_W + 3)'(i);
    return w[2:0];
  endfunction

endpackage
`default_nettype wire

[rtl/ptst_store.sv]
// Slot storage: callback, countdown and reload per slot.
// One read/write port for the scan plus a callback clear port. Uses ptst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptst_store import ptst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output entry_t                rd_entry_o,
  input  wire logic             wr_en_i,
  input  wire entry_t           wr_entry_i,
  input  wire logic             clr_en_i,
  input  wire logic [IDX_W-1:0] clr_idx_i
);

  logic [15:0] cb_q  [SLOTS];
  logic [31:0] cnt_q [SLOTS];
  logic [31:0] rld_q [SLOTS];

  assign rd_entry_o = '{cb: cb_q[rd_idx_i], cnt: cnt_q[rd_idx_i], rld: rld_q[rd_idx_i]};

  // free flag lives in the callback id, so only it needs reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) cb_q[i] <= '0;
    end else if (wr_en_i) begin
      cb_q[rd_idx_i] <= wr_entry_i.cb;
    end else if (clr_en_i) begin
      cb_q[clr_idx_i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cnt_q[rd_idx_i] <= wr_entry_i.cnt;
      rld_q[rd_idx_i] <= wr_entry_i.rld;
    end
  end

endmodule
`default_nettype wire

[rtl/ptst_unit.sv]
// Shared slot unit: id compare for set, zero test and decrement or reload for tick.
// Purely combinational; one slot per use. Uses ptst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptst_unit import ptst_pkg::*; (
  input  wire logic        op_i,
  input  wire entry_t      entry_i,
  input  wire logic [15:0] cb_i,
  input  wire logic [31:0] period_i,
  output unit_res_t        res_o
);

  logic occupied;
  logic zero;

  assign occupied = (entry_i.cb != 16'd0);
  assign zero     = (entry_i.cnt == 32'd0);

  always_comb begin
    res_o = '0;
    case (op_i)
      UOP_SET: begin
        res_o.hit = (entry_i.cb == cb_i) || !occupied;
        res_o.wr  = res_o.hit;
        res_o.nxt = '{cb: cb_i, cnt: period_i, rld: period_i};
      end
      UOP_TICK: begin
        res_o.wr   = occupied;
        res_o.fire = occupied && zero;
        res_o.nxt  = '{cb: entry_i.cb,
                       cnt: zero ? entry_i.rld : entry_i.cnt - 32'd1,
                       rld: entry_i.rld};
      end
      default: res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/periodic_timer_slot_table.sv]
// Periodic timer slot table, top level: sequencer, result register.
// Set: scans from slot 0 and stops at the first hit; reply strobe the cycle after.
// Tick: one slot per cycle through the shared unit, then a final END state for the
//   held fire word. Remove and ignored ticks do not raise busy.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears all slots to free and control state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module periodic_timer_slot_table import ptst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] callback_id_i,
  input  wire logic [31:0] period_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic        slot_valid_i,
  output logic             res_valid_o,
  output logic             result_kind_o,
  output logic [2:0]       slot_res_o,
  output logic             set_ok_o,
  output logic [15:0]      fired_callback_o,
  output logic             last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SET  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      cb_q, cb_d;
  logic [31:0]      per_q, per_d;
  logic             ever_q, ever_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             pend_q, pend_d;
  logic [2:0]       pslot_q, pslot_d;
  logic [15:0]      pcb_q, pcb_d;

  logic             vld_q, vld_d;
  logic             rk_q, rk_d;
  logic [2:0]       rs_q, rs_d;
  logic             ok_q, ok_d;
  logic [15:0]      fc_q, fc_d;
  logic             lst_q, lst_d;

  logic             accept;
  logic             at_end;
  logic             clr_en;
  logic [IDX_W+2:0] clr_ext;
  entry_t           rd_entry;
  unit_res_t        ures;
  logic             uop;
  logic             wr_en;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign at_end = (idx_q == IDX_W'(SLOTS - 1));
  assign uop    = (state_q == ST_TICK) ? UOP_TICK : UOP_SET;
  assign wr_en  = ((state_q == ST_SET) || (state_q == ST_TICK)) && ures.wr;

  assign clr_ext = (IDX_W + 3)'(slot_i);
  assign clr_en  = accept && (kind_i == KIND_REMOVE) && slot_valid_i &&
                   ((IDX_W + 3)'(slot_i) < (IDX_W + 3)'(SLOTS));

  ptst_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_entry_i (ures.nxt),
    .clr_en_i   (clr_en),
    .clr_idx_i  (clr_ext[IDX_W-1:0])
  );

  ptst_unit u_unit (
    .op_i     (uop),
    .entry_i  (rd_entry),
    .cb_i     (cb_q),
    .period_i (per_q),
    .res_o    (ures)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cb_d    = cb_q;
    per_d   = per_q;
    ever_d  = ever_q;
    n_d     = n_q;
    pend_d  = pend_q;
    pslot_d = pslot_q;
    pcb_d   = pcb_q;
    vld_d   = 1'b0;
    rk_d    = rk_q;
    rs_d    = rs_q;
    ok_d    = ok_q;
    fc_d    = fc_q;
    lst_d   = lst_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cb_d  = callback_id_i;
          per_d = period_i;
          idx_d = '0;
          n_d   = '0;
          if (kind_i == KIND_SET) begin
            state_d = ST_SET;
          end else if (kind_i == KIND_TICK && ever_q) begin
            state_d = ST_TICK;
          end
        end
      end
      ST_SET: begin
        if (ures.hit || at_end) begin
          vld_d   = 1'b1;
          rk_d    = RES_REPLY;
          rs_d    = ures.hit ? slot3(idx_q) : 3'd0;
          ok_d    = ures.hit;
          fc_d    = 16'd0;
          lst_d   = 1'b1;
          ever_d  = ever_q || ures.hit;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TICK: begin
        // each fire is held until the next one or the end state, so the final one can carry last
        if (ures.fire && (n_q < CNT_W'(MAX_RESULTS))) begin
          if (pend_q) begin
            vld_d = 1'b1;
            rk_d  = RES_FIRE;
            rs_d  = pslot_q;
            ok_d  = 1'b0;
            fc_d  = pcb_q;
            lst_d = 1'b0;
          end
          pend_d  = 1'b1;
          pslot_d = slot3(idx_q);
          pcb_d   = rd_entry.cb;
          n_d     = n_q + 1'b1;
        end
        if (at_end) begin
          state_d = ST_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_END: begin
        if (pend_q) begin
          vld_d = 1'b1;
          rk_d  = RES_FIRE;
          rs_d  = pslot_q;
          ok_d  = 1'b0;
          fc_d  = pcb_q;
          lst_d = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ever_q  <= 1'b0;
      n_q     <= '0;
      pend_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ever_q  <= ever_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q    <= cb_d;
    per_q   <= per_d;
    pslot_q <= pslot_d;
    pcb_q   <= pcb_d;
    rk_q    <= rk_d;
    rs_q    <= rs_d;
    ok_q    <= ok_d;
    fc_q    <= fc_d;
    lst_q   <= lst_d;
  end

  assign res_valid_o      = vld_q;
  assign result_kind_o    = rk_q;
  assign slot_res_o       = rs_q;
  assign set_ok_o         = ok_q;
  assign fired_callback_o = fc_q;
  assign last_o           = lst_q;

  // a word only comes out of a scan
  `ASSERT_AR(a_word_after_scan, clk_i, rst_ni, res_valid_o |-> $past(busy))
  // a set reply always ends its scan
  `ASSERT_AR(a_reply_ends_scan, clk_i, rst_ni,
             (res_valid_o && (result_kind_o == RES_REPLY)) |-> (!busy && last_o))
  // busy only begins on an accepted word
  `ASSERT_AR(a_busy_from_start, clk_i, rst_ni, $rose(busy) |-> $past(start))
  // nothing is held over once idle
  `ASSERT_NR(a_idle_no_pend, clk_i, (rst_ni && !busy) |-> !pend_q)

endmodule
`default_nettype wire
